/* hdl/cma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg
// shared constants and types of the centered moving average filter
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int MAX_HALF_WIDTH = 31;
   localparam int ROW_COUNT_BITS = 20;

   localparam int SAMPLE_BITS  = 16;
   localparam int SUM_BITS     = 22;
   localparam int HW_BITS      = 5;
   localparam int STORE_DEPTH  = 2 * MAX_HALF_WIDTH + 1;
   localparam int SLOT_BITS    = $clog2(STORE_DEPTH);
   localparam int W_BITS       = $clog2(MAX_HALF_WIDTH + 1);
   localparam int LEN_BITS     = $clog2(STORE_DEPTH + 1);
   localparam int DIV_STEPS    = SUM_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
   localparam int REM_BITS     = LEN_BITS;

   // divider start request
   typedef struct packed {
      logic                       start;
      logic signed [SUM_BITS-1:0] dividend;
      logic [LEN_BITS-1:0]        divisor;
   } div_req_type;

   // divider completion
   typedef struct packed {
      logic                   done;
      logic [SAMPLE_BITS-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

/* hdl/cma_window_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_window_store
// sample ring, one write and one registered read port
// ----------------------------------------------------------------------------
module cma_window_store (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [cma_pkg::SLOT_BITS-1:0]   rd_addr,
   output logic [cma_pkg::SAMPLE_BITS-1:0] rd_data,
   input  logic                            wr_en,
   input  logic [cma_pkg::SLOT_BITS-1:0]   wr_addr,
   input  logic [cma_pkg::SAMPLE_BITS-1:0] wr_data
);
   import cma_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/cma_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_divider
// restoring signed divide, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module cma_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cma_pkg::div_req_type div_req,
   output cma_pkg::div_rsp_type div_rsp
);
   import cma_pkg::*;

   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [SUM_BITS-1:0]     mag_ff, mag_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [LEN_BITS-1:0]     div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic [REM_BITS:0]       trial;
   logic                    fits;
   logic [SUM_BITS-1:0]     signed_q;

   assign trial = {rem_ff, mag_ff[SUM_BITS-1]};
   assign fits  = trial >= (REM_BITS + 1)'(div_ff);

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         cnt_in = DIV_CNT_BITS'(DIV_STEPS);
         neg_in = div_req.dividend[SUM_BITS-1];
         mag_in = div_req.dividend[SUM_BITS-1] ? (~div_req.dividend + 1'b1)
                                               : div_req.dividend;
         rem_in = '0;
         div_in = div_req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_BITS'(1));
         mag_in  = {mag_ff[SUM_BITS-2:0], fits};
         rem_in  = fits ? REM_BITS'(trial - (REM_BITS + 1)'(div_ff))
                        : trial[REM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign signed_q         = neg_ff ? (~mag_ff + 1'b1) : mag_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = signed_q[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

/* hdl/centered_moving_average_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centered_moving_average_filter_unit
// centered moving average over one column of samples
// ----------------------------------------------------------------------------
// Samples of one column enter in row order, tlast on the final row. The
// result for row r leaves once row r+w has arrived: the average of rows
// r-w..r+w truncated toward zero, or zero with tuser set for the first and
// last w rows. The final input flushes the pending edge rows. One sample is
// taken at a time: an interior row passes through the sum update, a 22-step
// bit-serial divide, its done flag, the hand-over of the result once the
// output register is free, and an idle state in which the next transaction
// and its ring read are taken; an edge row skips the divide, a row that
// releases nothing goes from the update straight back to idle, and the flush
// hands out the pending rows one by one. The divider sets the rate unless the
// output stalls. A new sample is accepted while a result still waits in the
// output register. half_width may only be written while the block is idle.
// ----------------------------------------------------------------------------
module centered_moving_average_filter_unit (
   input  logic                            clock,
   input  logic                            reset,
   // config
   input  logic                            csr_wr_en,
   input  logic [cma_pkg::HW_BITS-1:0]     csr_wr_data,   // half_width
   // sample stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cma_pkg::SAMPLE_BITS-1:0] req_tdata,     // [15:0] sample
   input  logic                            req_tlast,     // sample_last
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cma_pkg::SAMPLE_BITS-1:0] rsp_tdata,     // [15:0] filtered
   output logic                            rsp_tuser,     // is_edge
   output logic                            rsp_tlast      // result_last
);
   import cma_pkg::*;

   // controller states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MAIN  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   localparam int AEXT = SLOT_BITS + 1;

   // state
   logic [2:0]                state_ff, state_in;
   logic [HW_BITS-1:0]        hw_ff, hw_in;
   logic [SLOT_BITS-1:0]      slot_ff, slot_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [ROW_COUNT_BITS-1:0] rows_ff, rows_in;

   // latched transaction
   logic [SAMPLE_BITS-1:0]    samp_ff, samp_in;
   logic                      last_ff, last_in;
   logic [ROW_COUNT_BITS-1:0] row_ff, row_in;
   logic [W_BITS-1:0]         w_ff, w_in;
   logic [W_BITS-1:0]         pend_ff, pend_in;
   logic [SAMPLE_BITS-1:0]    res_ff, res_in;
   logic                      res_edge_ff, res_edge_in;

   // output register
   logic                      ov_ff, ov_in;
   logic [SAMPLE_BITS-1:0]    od_ff, od_in;
   logic                      oe_ff, oe_in;
   logic                      ol_ff, ol_in;

   logic                      req_fire;
   logic                      out_free;
   logic [W_BITS-1:0]         w_now;
   logic [LEN_BITS-1:0]       len_now;
   logic [LEN_BITS-1:0]       len_ff;
   logic [LEN_BITS-1:0]       two_w_ff;
   logic [AEXT-1:0]           rd_addr_ext;
   logic [SAMPLE_BITS-1:0]    rd_data;
   logic signed [SUM_BITS-1:0] samp_ext, old_ext, new_sum;
   logic                      full_window;
   logic                      row_ge_w, row_ge_2w;
   logic [W_BITS-1:0]         pending;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   // clamp half width, window length 2w+1
   assign w_now   = (32'(hw_ff) > 32'(MAX_HALF_WIDTH)) ? W_BITS'(MAX_HALF_WIDTH)
                                                       : W_BITS'(hw_ff);
   assign len_now  = LEN_BITS'({w_now, 1'b1});
   assign len_ff   = LEN_BITS'({w_ff, 1'b1});
   assign two_w_ff = LEN_BITS'({w_ff, 1'b0});

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !ov_ff || rsp_tready;

   // slot of the sample that leaves the window, (slot - len) mod depth
   always_comb begin
      if (AEXT'(slot_ff) >= AEXT'(len_now)) begin
         rd_addr_ext = AEXT'(slot_ff) - AEXT'(len_now);
      end else begin
         rd_addr_ext = AEXT'(slot_ff) + AEXT'(STORE_DEPTH) - AEXT'(len_now);
      end
   end

   cma_window_store u_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rd_addr_ext[SLOT_BITS-1:0]),
      .rd_data (rd_data),
      .wr_en   (state_ff == ST_SUM),
      .wr_addr (slot_ff),
      .wr_data (samp_ff)
   );

   // running sum update, wraps at sum width
   assign full_window = row_ff >= ROW_COUNT_BITS'(len_ff);
   assign samp_ext = {{(SUM_BITS - SAMPLE_BITS){samp_ff[SAMPLE_BITS-1]}}, samp_ff};
   assign old_ext  = full_window ? {{(SUM_BITS - SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}},
                                    rd_data}
                                 : '0;
   assign new_sum  = sum_ff - old_ext + samp_ext;

   assign row_ge_w  = row_ff >= ROW_COUNT_BITS'(w_ff);
   assign row_ge_2w = row_ff >= ROW_COUNT_BITS'(two_w_ff);
   // rows still owed at the end of the column
   assign pending   = row_ge_w ? w_ff : W_BITS'(row_ff + 1'b1);

   assign div_req.start    = (state_ff == ST_SUM) && row_ge_w && row_ge_2w;
   assign div_req.dividend = new_sum;
   assign div_req.divisor  = len_ff;

   cma_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in    = state_ff;
      hw_in       = csr_wr_en ? csr_wr_data : hw_ff;
      slot_in     = slot_ff;
      sum_in      = sum_ff;
      rows_in     = rows_ff;
      samp_in     = samp_ff;
      last_in     = last_ff;
      row_in      = row_ff;
      w_in        = w_ff;
      pend_in     = pend_ff;
      res_in      = res_ff;
      res_edge_in = res_edge_ff;
      ov_in       = ov_ff && !rsp_tready;
      od_in       = od_ff;
      oe_in       = oe_ff;
      ol_in       = ol_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               samp_in  = req_tdata;
               last_in  = req_tlast;
               row_in   = rows_ff;
               w_in     = w_now;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // ring written this cycle, column state advances
            pend_in = pending;
            if (last_ff) begin
               sum_in  = '0;
               slot_in = '0;
               rows_in = '0;
            end else begin
               sum_in  = new_sum;
               slot_in = (slot_ff == SLOT_BITS'(STORE_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               if (!(&rows_ff)) begin
                  rows_in = rows_ff + 1'b1;
               end
            end
            if (row_ge_w && row_ge_2w) begin
               state_in = ST_DIV;
            end else if (row_ge_w) begin
               // leading edge row
               res_in      = '0;
               res_edge_in = 1'b1;
               state_in    = ST_MAIN;
            end else if (last_ff) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in      = div_rsp.quotient;
               res_edge_in = 1'b0;
               state_in    = ST_MAIN;
            end
         end
         ST_MAIN: begin
            if (out_free) begin
               ov_in = 1'b1;
               od_in = res_ff;
               oe_in = res_edge_ff;
               ol_in = last_ff && (w_ff == '0);
               state_in = (last_ff && pend_ff != '0) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            // trailing zeroed rows
            if (out_free) begin
               ov_in   = 1'b1;
               od_in   = '0;
               oe_in   = 1'b1;
               ol_in   = (pend_ff == W_BITS'(1));
               pend_in = pend_ff - 1'b1;
               if (pend_ff == W_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hw_ff    <= HW_BITS'(1);
         slot_ff  <= '0;
         sum_ff   <= '0;
         rows_ff  <= '0;
         pend_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hw_ff    <= hw_in;
         slot_ff  <= slot_in;
         sum_ff   <= sum_in;
         rows_ff  <= rows_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      last_ff     <= last_in;
      row_ff      <= row_in;
      w_ff        <= w_in;
      res_ff      <= res_in;
      res_edge_ff <= res_edge_in;
      od_ff       <= od_in;
      oe_ff       <= oe_in;
      ol_ff       <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = oe_ff;
   assign rsp_tlast  = ol_ff;

   // checks
   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SUM)
      else $error("accepted sample did not move to the sum update");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide wait");

   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> pend_ff != '0)
      else $error("flush with no pending rows");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < STORE_DEPTH)
      else $error("ring slot beyond store depth");

endmodule
`default_nettype wire
